// File: sv/pes_pkg.sv
package pes_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CHILD_W     = IDX_W + 2;
    localparam int ID_W        = 16;
    localparam int PER_W       = 16;
    localparam int DUE_W       = 40;
    localparam int ST_W        = 3;

    typedef enum logic [ST_W-1:0] {
        ST_REGISTERED  = 3'd0,
        ST_FULL        = 3'd1,
        ST_ZERO_PERIOD = 3'd2,
        ST_EMITTED     = 3'd3,
        ST_EMPTY       = 3'd4
    } pes_status_t;

    typedef struct packed {
        logic [DUE_W-1:0] due;
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] per;
    } pes_entry_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TAKE,
        OP_REG_INIT,
        OP_UP_RD,
        OP_UP_STEP,
        OP_FETCH_INIT,
        OP_TAKE_ROOT,
        OP_DN_RD,
        OP_DN_STEP,
        OP_PLACE,
        OP_EMIT
    } pes_op_t;

    typedef struct packed {
        logic req;
        logic fetch;
        logic reject;
        logic root;
        logic up_moved;
        logic dn_moved;
        logic empty;
        logic no_left;
        logic out_free;
    } pes_flags_t;

    // order by due time, then id, then period
    function automatic logic ent_before(pes_entry_t a, pes_entry_t b);
        return a < b;
    endfunction

endpackage

// File: sv/pes_seq.sv
module pes_seq
    import pes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pes_flags_t flags,
    output pes_op_t    op
);

    localparam int STEP_W = 4;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_REQ,
        C_FETCH,
        C_REJECT,
        C_ROOT,
        C_UP_MOVED,
        C_DN_MOVED,
        C_EMPTY,
        C_NO_LEFT,
        C_OUT_FREE
    } pes_cond_t;

    typedef struct packed {
        pes_op_t           op;
        pes_cond_t         cond;
        logic [STEP_W-1:0] target;
        logic              hold;
    } pes_uword_t;

    localparam logic [STEP_W-1:0] S_WAIT       = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH   = 4'd1;
    localparam logic [STEP_W-1:0] S_REG_INIT   = 4'd2;
    localparam logic [STEP_W-1:0] S_UP_RD      = 4'd3;
    localparam logic [STEP_W-1:0] S_UP_STEP    = 4'd4;
    localparam logic [STEP_W-1:0] S_UP_PLACE   = 4'd5;
    localparam logic [STEP_W-1:0] S_FETCH_INIT = 4'd6;
    localparam logic [STEP_W-1:0] S_TAKE_ROOT  = 4'd7;
    localparam logic [STEP_W-1:0] S_DN_RD      = 4'd8;
    localparam logic [STEP_W-1:0] S_DN_STEP    = 4'd9;
    localparam logic [STEP_W-1:0] S_DN_PLACE   = 4'd10;
    localparam logic [STEP_W-1:0] S_RESULT     = 4'd11;

    function automatic pes_uword_t rom(logic [STEP_W-1:0] s);
        pes_uword_t w;
        case (s)
            S_WAIT:       w = '{OP_TAKE,       C_REQ,      S_DISPATCH,   1'b1};
            S_DISPATCH:   w = '{OP_NOP,        C_FETCH,    S_FETCH_INIT, 1'b0};
            S_REG_INIT:   w = '{OP_REG_INIT,   C_REJECT,   S_RESULT,     1'b0};
            S_UP_RD:      w = '{OP_UP_RD,      C_ROOT,     S_UP_PLACE,   1'b0};
            S_UP_STEP:    w = '{OP_UP_STEP,    C_UP_MOVED, S_UP_RD,      1'b0};
            S_UP_PLACE:   w = '{OP_PLACE,      C_ALWAYS,   S_RESULT,     1'b0};
            S_FETCH_INIT: w = '{OP_FETCH_INIT, C_EMPTY,    S_RESULT,     1'b0};
            S_TAKE_ROOT:  w = '{OP_TAKE_ROOT,  C_NEVER,    S_WAIT,       1'b0};
            S_DN_RD:      w = '{OP_DN_RD,      C_NO_LEFT,  S_DN_PLACE,   1'b0};
            S_DN_STEP:    w = '{OP_DN_STEP,    C_DN_MOVED, S_DN_RD,      1'b0};
            S_DN_PLACE:   w = '{OP_PLACE,      C_NEVER,    S_WAIT,       1'b0};
            S_RESULT:     w = '{OP_EMIT,       C_OUT_FREE, S_WAIT,       1'b1};
            default:      w = '{OP_NOP,        C_ALWAYS,   S_WAIT,       1'b0};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    pes_uword_t        uword;
    logic              cond_true;

    assign uword = rom(step_reg);
    assign op    = uword.op;

    always_comb
    begin
        case (uword.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_REQ:      cond_true = flags.req;
            C_FETCH:    cond_true = flags.fetch;
            C_REJECT:   cond_true = flags.reject;
            C_ROOT:     cond_true = flags.root;
            C_UP_MOVED: cond_true = flags.up_moved;
            C_DN_MOVED: cond_true = flags.dn_moved;
            C_EMPTY:    cond_true = flags.empty;
            C_NO_LEFT:  cond_true = flags.no_left;
            C_OUT_FREE: cond_true = flags.out_free;
            default:    cond_true = 1'b1;
        endcase

        if (cond_true)
        begin
            step_next = uword.target;
        end
        else if (uword.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: sv/periodic_event_scheduler.sv
// Earliest-deadline scheduler for up to 1024 periodic entries, kept as a binary min-heap in a
// one-write, two-read memory with registered read data. cmd 0 registers an entry whose first due
// time is its period; cmd 1 returns the entry with the earliest due time (ties by smaller id, then
// smaller period) and puts it back due time plus period later, saturating at 2^40 - 1. Every
// request gives exactly one result. One request is worked at a time by a small microprogram:
// each heap level costs one memory read step and one compare-and-write step, so a register or a
// fetch runs longer for each level the entry moves; a rejected register or a fetch on an empty
// table skips the heap walk. The next request is taken while a result waits in the output
// register.
module periodic_event_scheduler
    import pes_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cmd,
    input  logic [ID_W-1:0]  entry_id,
    input  logic [PER_W-1:0] entry_period,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ST_W-1:0]  status,
    output logic [ID_W-1:0]  due_id,
    output logic [DUE_W-1:0] due_time
);

    pes_op_t    op;
    pes_flags_t flags;

    pes_entry_t heap_reg [TABLE_DEPTH];
    pes_entry_t rd0_reg;
    pes_entry_t rd1_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    pes_entry_t       wr_data;
    logic [IDX_W-1:0] rd0_addr;
    logic [IDX_W-1:0] rd1_addr;

    logic             cmd_reg,        cmd_next;
    logic [ID_W-1:0]  id_reg,         id_next;
    logic [PER_W-1:0] per_reg,        per_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [IDX_W-1:0] hole_reg,       hole_next;
    pes_entry_t       e_reg,          e_next;
    pes_status_t      res_status_reg, res_status_next;
    logic [ID_W-1:0]  res_id_reg,     res_id_next;
    logic [DUE_W-1:0] res_due_reg,    res_due_next;
    logic             out_valid_reg,  out_valid_next;
    pes_status_t      out_status_reg, out_status_next;
    logic [ID_W-1:0]  out_id_reg,     out_id_next;
    logic [DUE_W-1:0] out_due_reg,    out_due_next;

    logic [IDX_W-1:0]   hole_dec;
    logic [IDX_W-1:0]   par_idx;
    logic [CHILD_W-1:0] l_idx;
    logic [CHILD_W-1:0] r_idx;
    logic [CHILD_W-1:0] count_ext;
    logic               r_ok;
    logic               l_lt_e;
    logic               r_lt_e;
    logic               r_lt_l;
    logic               pick_r;
    logic               out_free;
    logic [DUE_W:0]     due_sum;
    logic [DUE_W-1:0]   due_sat;

    pes_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    assign in_stall  = (op != OP_TAKE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign due_id    = out_id_reg;
    assign due_time  = out_due_reg;

    assign hole_dec  = hole_reg - IDX_W'(1);
    assign par_idx   = hole_dec >> 1;
    assign l_idx     = {1'b0, hole_reg, 1'b1};
    assign r_idx     = l_idx + CHILD_W'(1);
    assign count_ext = CHILD_W'(count_reg);
    assign r_ok      = (r_idx < count_ext);
    assign l_lt_e    = ent_before(rd0_reg, e_reg);
    assign r_lt_e    = ent_before(rd1_reg, e_reg);
    assign r_lt_l    = ent_before(rd1_reg, rd0_reg);
    assign pick_r    = r_ok && (l_lt_e ? r_lt_l : r_lt_e);
    assign out_free  = !out_valid_reg || !out_stall;
    assign due_sum   = {1'b0, rd0_reg.due} + (DUE_W + 1)'(rd0_reg.per);
    assign due_sat   = due_sum[DUE_W] ? {DUE_W{1'b1}} : due_sum[DUE_W-1:0];

    always_comb
    begin
        flags.req      = in_valid;
        flags.fetch    = cmd_reg;
        flags.reject   = (per_reg == '0) || (count_reg == CNT_W'(TABLE_DEPTH));
        flags.root     = (hole_reg == '0);
        flags.up_moved = ent_before(e_reg, rd0_reg);
        flags.dn_moved = l_lt_e || pick_r;
        flags.empty    = (count_reg == '0);
        flags.no_left  = (l_idx >= count_ext);
        flags.out_free = out_free;
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        per_next        = per_reg;
        count_next      = count_reg;
        hole_next       = hole_reg;
        e_next          = e_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_due_next    = res_due_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_due_next    = out_due_reg;
        wr_en           = 1'b0;
        wr_addr         = hole_reg;
        wr_data         = e_reg;
        rd0_addr        = '0;
        rd1_addr        = '0;

        case (op)
            OP_TAKE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    id_next      = entry_id;
                    per_next     = entry_period;
                    res_id_next  = '0;
                    res_due_next = '0;
                end
            end
            OP_REG_INIT:
            begin
                if (per_reg == '0)
                begin
                    res_status_next = ST_ZERO_PERIOD;
                end
                else if (count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    res_status_next = ST_REGISTERED;
                    e_next          = '{due: DUE_W'(per_reg), id: id_reg, per: per_reg};
                    hole_next       = count_reg[IDX_W-1:0];
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            OP_UP_RD:
            begin
                rd0_addr = par_idx;
            end
            OP_UP_STEP:
            begin
                if (flags.up_moved)
                begin
                    wr_en     = 1'b1;
                    wr_data   = rd0_reg;
                    hole_next = par_idx;
                end
            end
            OP_FETCH_INIT:
            begin
                res_status_next = (count_reg == '0) ? ST_EMPTY : ST_EMITTED;
                hole_next       = '0;
            end
            OP_TAKE_ROOT:
            begin
                res_id_next  = rd0_reg.id;
                res_due_next = rd0_reg.due;
                e_next       = '{due: due_sat, id: rd0_reg.id, per: rd0_reg.per};
            end
            OP_DN_RD:
            begin
                rd0_addr = l_idx[IDX_W-1:0];
                rd1_addr = r_idx[IDX_W-1:0];
            end
            OP_DN_STEP:
            begin
                if (pick_r)
                begin
                    wr_en     = 1'b1;
                    wr_data   = rd1_reg;
                    hole_next = r_idx[IDX_W-1:0];
                end
                else if (l_lt_e)
                begin
                    wr_en     = 1'b1;
                    wr_data   = rd0_reg;
                    hole_next = l_idx[IDX_W-1:0];
                end
            end
            OP_PLACE:
            begin
                wr_en = 1'b1;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_due_next    = res_due_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_reg[wr_addr] <= wr_data;
        end
        rd0_reg <= heap_reg[rd0_addr];
        rd1_reg <= heap_reg[rd1_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= 1'b0;
            id_reg         <= '0;
            per_reg        <= '0;
            count_reg      <= '0;
            hole_reg       <= '0;
            e_reg          <= '0;
            res_status_reg <= ST_REGISTERED;
            res_id_reg     <= '0;
            res_due_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_REGISTERED;
            out_id_reg     <= '0;
            out_due_reg    <= '0;
        end
        else
        begin
            cmd_reg        <= cmd_next;
            id_reg         <= id_next;
            per_reg        <= per_next;
            count_reg      <= count_next;
            hole_reg       <= hole_next;
            e_reg          <= e_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_due_reg    <= res_due_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_due_reg    <= out_due_next;
        end
    end

endmodule

// File: sv/pes_chk.sv
module pes_chk
    import pes_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             cmd,
    input logic [ID_W-1:0]  entry_id,
    input logic [PER_W-1:0] entry_period,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ST_W-1:0]  status,
    input logic [ID_W-1:0]  due_id,
    input logic [DUE_W-1:0] due_time
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(due_id)
            && $stable(due_time))
        else $error("stalled result changed");

    // stall further requests while one is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_REGISTERED || status == ST_FULL
            || status == ST_ZERO_PERIOD || status == ST_EMITTED || status == ST_EMPTY)
        else $error("bad status");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_EMITTED |-> due_id == '0 && due_time == '0)
        else $error("nonzero payload without emit");

    // a result never appears in the cycle right after its request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result too early");

endmodule

bind periodic_event_scheduler pes_chk u_pes_chk (.*);
